@@ src/llte_pkg.sv @@
// llte_pkg: shared types, constants and helpers for the linked list table engine
// no dependencies; imported by linked_list_table_engine
package llte_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int SLOT_W = $clog2(POOL_DEPTH);
	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W = 7;
	localparam int CNT_W = 7;
	localparam int FIDX_W = 6;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK = 3'd1,
		MODE_GET = 3'd2,
		MODE_INSERT = 3'd3,
		MODE_REMOVE = 3'd4,
		MODE_FIND = 3'd5,
		MODE_CLEAR = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_INDEX = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_WALK,
		S_WEV,
		S_PRD,
		S_PEV,
		S_VRD,
		S_VEV,
		S_ARD,
		S_AEV,
		S_LINK,
		S_UNLINK,
		S_FREE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0] position;
		logic signed [VALUE_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		status_t status;
		logic signed [VALUE_W-1:0] read_value;
		logic found;
		logic [FIDX_W-1:0] found_index;
		logic [CNT_W-1:0] hops;
		logic [CNT_W-1:0] length;
	} rsp_t;

	// out-of-pool links read as null
	function automatic logic [LINK_W-1:0] link_clamp(input logic [LINK_W-1:0] l);
		return (l >= NULL_LINK) ? NULL_LINK : l;
	endfunction

endpackage

@@ src/linked_list_table_engine.sv @@
// linked_list_table_engine: singly linked list of signed 32-bit values in a fixed node pool
// depends on llte_pkg and llte_ram (node value store and node link store)
//
// One request is handled at a time; req_stall is high from acceptance until the result
// is loaded into the output register, which may still wait on rsp_stall while the next
// request is taken. A list walk follows one link per hop, and its hop rate is set by the single
// read port of the link ram, one read per hop. Clear takes effect at once through
// per-slot link valid bits, and no clearing pass runs after reset.
module linked_list_table_engine (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input llte_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output llte_pkg::rsp_t rsp
);

	import llte_pkg::*;

	state_t state_q, state_d, after_walk;

	mode_t mode_q;
	logic [POS_W-1:0] pos_q;
	logic signed [VALUE_W-1:0] val_q;

	logic [LINK_W-1:0] head_q, free_q, cur_q, next_q, victim_q, vnext_q, slot_q;
	logic [CNT_W-1:0] count_q, cnt_q, tgt_q;
	logic [POOL_DEPTH-1:0] lv_q;

	status_t status_q;
	logic signed [VALUE_W-1:0] rdv_q;
	logic found_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [CNT_W-1:0] hops_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [LINK_W-1:0] addr_s1;
	logic hit_s1;

	logic rd_req;
	logic [LINK_W-1:0] rd_slot;
	logic lwr_en;
	logic [LINK_W-1:0] lwr_slot, lwr_data;
	logic vwr_en;

	logic [LINK_W-1:0] lram_rd;
	logic [VALUE_W-1:0] vram_rd;
	logic [LINK_W-1:0] link_out;
	logic signed [VALUE_W-1:0] value_out;

	logic full, pos_ge, pos_gt, pos_zero, empty, out_free;
	logic walk_done, wev_last, find_hit, link_to_cur;

	assign full = free_q >= NULL_LINK;
	assign pos_ge = pos_q >= POS_W'(count_q);
	assign pos_gt = pos_q > POS_W'(count_q);
	assign pos_zero = pos_q == '0;
	assign empty = (count_q == '0) || (head_q >= NULL_LINK);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign link_out = (addr_s1 >= NULL_LINK) ? NULL_LINK :
		(hit_s1 ? link_clamp(lram_rd) : addr_s1 + LINK_W'(1));
	assign value_out = (addr_s1 >= NULL_LINK) ? '0 : vram_rd;

	assign walk_done = (cnt_q == tgt_q) || (cur_q >= NULL_LINK);
	assign wev_last = (cnt_q + CNT_W'(1) == tgt_q) || (link_out >= NULL_LINK);
	assign find_hit = (mode_q == MODE_FIND) && (value_out == val_q);
	assign link_to_cur = (mode_q == MODE_PUSH_BACK) ? !empty :
		((mode_q == MODE_INSERT) && !pos_zero);

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	llte_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk(clk),
		.wr_en(lwr_en),
		.wr_addr(lwr_slot[SLOT_W-1:0]),
		.wr_data(lwr_data),
		.rd_en(rd_req && (rd_slot < NULL_LINK)),
		.rd_addr(rd_slot[SLOT_W-1:0]),
		.rd_data(lram_rd)
	);

	llte_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_value_ram (
		.clk(clk),
		.wr_en(vwr_en),
		.wr_addr(free_q[SLOT_W-1:0]),
		.wr_data(val_q),
		.rd_en(rd_req && (rd_slot < NULL_LINK)),
		.rd_addr(rd_slot[SLOT_W-1:0]),
		.rd_data(vram_rd)
	);

	always_comb begin
		unique case (mode_q)
			MODE_PUSH_BACK: after_walk = S_ARD;
			MODE_GET: after_walk = S_VRD;
			MODE_INSERT, MODE_REMOVE: after_walk = S_PRD;
			default: after_walk = S_OUT;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (mode_q)
					MODE_PUSH_FRONT: state_d = full ? S_OUT : S_ARD;
					MODE_PUSH_BACK: state_d = full ? S_OUT : (empty ? S_ARD : S_WALK);
					MODE_GET: state_d = pos_ge ? S_OUT : S_WALK;
					MODE_INSERT: state_d = (full || pos_gt) ? S_OUT : (pos_zero ? S_ARD : S_WALK);
					MODE_REMOVE: state_d = pos_ge ? S_OUT : (pos_zero ? S_VRD : S_WALK);
					MODE_FIND: state_d = S_WALK;
					default: state_d = S_OUT;
				endcase
			end
			S_WALK: state_d = walk_done ? after_walk : S_WEV;
			S_WEV: begin
				priority if (find_hit) state_d = S_OUT;
				else if (wev_last) state_d = after_walk;
				else state_d = S_WEV;
			end
			S_PRD: state_d = S_PEV;
			S_PEV: state_d = (mode_q == MODE_INSERT) ? S_ARD : S_VRD;
			S_VRD: state_d = S_VEV;
			S_VEV: begin
				priority if (mode_q == MODE_GET) state_d = S_OUT;
				else if (pos_zero) state_d = S_FREE;
				else state_d = S_UNLINK;
			end
			S_ARD: state_d = S_AEV;
			S_AEV: state_d = S_LINK;
			S_LINK: state_d = S_OUT;
			S_UNLINK: state_d = S_FREE;
			S_FREE: state_d = S_OUT;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_req = 1'b0;
		rd_slot = cur_q;
		lwr_en = 1'b0;
		lwr_slot = cur_q;
		lwr_data = slot_q;
		vwr_en = 1'b0;
		unique case (state_q)
			S_WALK: rd_req = !walk_done;
			S_WEV: begin
				rd_req = !find_hit && !wev_last;
				rd_slot = link_out;
			end
			S_PRD: rd_req = 1'b1;
			S_VRD: begin
				rd_req = 1'b1;
				rd_slot = (mode_q == MODE_GET) ? cur_q : victim_q;
			end
			S_ARD: begin
				rd_req = 1'b1;
				rd_slot = free_q;
			end
			S_AEV: begin
				lwr_en = free_q < NULL_LINK;
				lwr_slot = free_q;
				lwr_data = next_q;
				vwr_en = free_q < NULL_LINK;
			end
			S_LINK: lwr_en = link_to_cur && (cur_q < NULL_LINK);
			S_UNLINK: begin
				lwr_en = cur_q < NULL_LINK;
				lwr_data = vnext_q;
			end
			S_FREE: begin
				lwr_en = victim_q < NULL_LINK;
				lwr_slot = victim_q;
				lwr_data = free_q;
			end
			default: rd_req = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_req) begin
			addr_s1 <= rd_slot;
			hit_s1 <= (rd_slot < NULL_LINK) ? lv_q[rd_slot[SLOT_W-1:0]] : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NULL_LINK;
			free_q <= '0;
			count_q <= '0;
			lv_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			if (lwr_en) lv_q[lwr_slot[SLOT_W-1:0]] <= 1'b1;
			unique case (state_q)
				S_DISP: if (mode_q == MODE_CLEAR) begin
					lv_q <= '0;
					head_q <= NULL_LINK;
					free_q <= '0;
					count_q <= '0;
				end
				S_VEV: if (mode_q == MODE_REMOVE && pos_zero) head_q <= link_out;
				S_AEV: free_q <= link_out;
				S_LINK: begin
					if (!link_to_cur) head_q <= slot_q;
					count_q <= count_q + CNT_W'(1);
				end
				S_FREE: begin
					if (victim_q < NULL_LINK) free_q <= victim_q;
					count_q <= count_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req_valid) begin
				mode_q <= mode_t'(req.mode);
				pos_q <= req.position;
				val_q <= req.item_value;
			end
			S_DISP: begin
				rdv_q <= '0;
				found_q <= 1'b0;
				fidx_q <= '0;
				cur_q <= head_q;
				cnt_q <= '0;
				next_q <= (mode_q == MODE_PUSH_BACK) ? NULL_LINK : head_q;
				victim_q <= head_q;
				unique case (mode_q)
					MODE_PUSH_FRONT: begin
						if (full) status_q <= STATUS_FULL;
						else status_q <= STATUS_OK;
						hops_q <= '0;
						tgt_q <= '0;
					end
					MODE_PUSH_BACK: begin
						if (full) status_q <= STATUS_FULL;
						else status_q <= STATUS_OK;
						hops_q <= (full || empty) ? '0 : count_q - CNT_W'(1);
						tgt_q <= count_q - CNT_W'(1);
					end
					MODE_GET: begin
						if (pos_ge) status_q <= STATUS_BAD_INDEX;
						else status_q <= STATUS_OK;
						hops_q <= pos_ge ? '0 : CNT_W'(pos_q);
						tgt_q <= CNT_W'(pos_q);
					end
					MODE_INSERT: begin
						priority if (pos_gt) status_q <= STATUS_BAD_INDEX;
						else if (full) status_q <= STATUS_FULL;
						else status_q <= STATUS_OK;
						hops_q <= (pos_gt || full || pos_zero) ? '0 :
							CNT_W'(pos_q) - CNT_W'(1);
						tgt_q <= CNT_W'(pos_q) - CNT_W'(1);
					end
					MODE_REMOVE: begin
						if (pos_ge) status_q <= STATUS_BAD_INDEX;
						else status_q <= STATUS_OK;
						hops_q <= (pos_ge || pos_zero) ? '0 : CNT_W'(pos_q) - CNT_W'(1);
						tgt_q <= CNT_W'(pos_q) - CNT_W'(1);
					end
					MODE_FIND: begin
						status_q <= STATUS_OK;
						hops_q <= '0;
						tgt_q <= count_q;
					end
					default: begin
						status_q <= STATUS_OK;
						hops_q <= '0;
						tgt_q <= '0;
					end
				endcase
			end
			S_WEV: begin
				if (find_hit) begin
					found_q <= 1'b1;
					fidx_q <= cnt_q[FIDX_W-1:0];
				end else begin
					cur_q <= link_out;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_PEV: begin
				next_q <= link_out;
				victim_q <= link_out;
			end
			S_VEV: begin
				rdv_q <= value_out;
				vnext_q <= link_out;
			end
			S_AEV: slot_q <= free_q;
			S_OUT: if (out_free) begin
				rsp_q.status <= status_q;
				rsp_q.read_value <= rdv_q;
				rsp_q.found <= found_q;
				rsp_q.found_index <= fidx_q;
				rsp_q.hops <= (mode_q == MODE_FIND) ? cnt_q : hops_q;
				rsp_q.length <= count_q;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POOL_DEPTH))
		else $error("element count beyond pool depth");

	a_free_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((free_q >= NULL_LINK) == (count_q == CNT_W'(POOL_DEPTH))))
		else $error("free list and element count disagree");

	a_head_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((head_q >= NULL_LINK) == (count_q == '0)))
		else $error("head link and element count disagree");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (rsp_valid && state_q == S_IDLE))
		else $error("finished result not presented");

	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.hops <= rsp.length))
		else $error("hop count exceeds list length");
`endif

endmodule

@@ src/llte_ram.sv @@
// llte_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for the node value and node link stores
module llte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ tb/linked_list_table_engine_tb.sv @@
`timescale 1ns / 1ps
// linked_list_table_engine_tb: self-checking bench for the linked list table engine
// depends on llte_pkg and the engine rtl; every result is checked against a node pool predictor

module linked_list_table_engine_tb;
	import llte_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_AFTER = 600;
	localparam int HOLD_CYCLES = 500;
	localparam int DRAIN_CYCLES = 80;
	localparam int PRINT_LIMIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	linked_list_table_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predictor state
	logic [VALUE_W-1:0] node_val [POOL_DEPTH];
	logic [LINK_W-1:0] node_next [POOL_DEPTH];
	logic [LINK_W-1:0] head_ptr;
	logic [LINK_W-1:0] free_ptr;
	logic [CNT_W-1:0] list_len;

	req_t request_backlog [$];
	rsp_t list_results_due [$];
	logic [VALUE_W-1:0] recent_values [$];

	int gen_len = 0;
	int useful_queued = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int accepted_count = 0;
	int checked_count = 0;
	int error_count = 0;
	int full_seen = 0;
	int bad_seen = 0;
	int hit_seen = 0;
	int blocked_cycles = 0;
	int hold_left = 0;
	int quiet_left = 0;
	logic hold_done = 1'b0;
	rsp_t due_rsp;

	function automatic void empty_list();
		for (int k = 0; k < POOL_DEPTH; k++)
			node_next[k] = LINK_W'(k + 1);
		head_ptr = NULL_LINK;
		free_ptr = '0;
		list_len = '0;
	endfunction

	function automatic logic [LINK_W-1:0] follow(input logic [LINK_W-1:0] s);
		if (s >= NULL_LINK || node_next[s[SLOT_W-1:0]] >= NULL_LINK)
			return NULL_LINK;
		return node_next[s[SLOT_W-1:0]];
	endfunction

	function automatic logic [LINK_W-1:0] walk_links(input int unsigned n);
		logic [LINK_W-1:0] s;
		s = head_ptr;
		for (int unsigned i = 0; i < n && s != NULL_LINK; i++)
			s = follow(s);
		return s;
	endfunction

	function automatic logic [VALUE_W-1:0] slot_value(input logic [LINK_W-1:0] s);
		return (s < NULL_LINK) ? node_val[s[SLOT_W-1:0]] : '0;
	endfunction

	function automatic void relink(input logic [LINK_W-1:0] s, input logic [LINK_W-1:0] target);
		if (s < NULL_LINK)
			node_next[s[SLOT_W-1:0]] = target;
	endfunction

	function automatic logic [LINK_W-1:0] take_slot(input logic [VALUE_W-1:0] v,
			input logic [LINK_W-1:0] nxt);
		logic [LINK_W-1:0] s;
		s = free_ptr;
		free_ptr = follow(s);
		node_val[s[SLOT_W-1:0]] = v;
		node_next[s[SLOT_W-1:0]] = nxt;
		return s;
	endfunction

	function automatic void release_slot(input logic [LINK_W-1:0] s);
		if (s < NULL_LINK) begin
			node_next[s[SLOT_W-1:0]] = free_ptr;
			free_ptr = s;
		end
	endfunction

	function automatic rsp_t apply_list_request(input req_t r);
		rsp_t o;
		logic [LINK_W-1:0] s, prev, victim;
		int unsigned i;
		o = '0;
		o.status = STATUS_OK;
		if ((r.mode == MODE_PUSH_FRONT || r.mode == MODE_PUSH_BACK || r.mode == MODE_INSERT)
				&& free_ptr >= NULL_LINK) begin
			if (r.mode == MODE_INSERT && r.position > list_len)
				o.status = STATUS_BAD_INDEX;
			else
				o.status = STATUS_FULL;
		end else if (r.mode == MODE_PUSH_FRONT || (r.mode == MODE_INSERT && r.position == 0)) begin
			head_ptr = take_slot(r.item_value, head_ptr);
			list_len++;
		end else begin
			case (r.mode)
			MODE_PUSH_BACK: begin
				s = take_slot(r.item_value, NULL_LINK);
				if (list_len == 0 || head_ptr == NULL_LINK)
					head_ptr = s;
				else begin
					o.hops = list_len - CNT_W'(1);
					relink(walk_links(list_len - 1), s);
				end
				list_len++;
			end
			MODE_GET: begin
				if (r.position >= list_len)
					o.status = STATUS_BAD_INDEX;
				else begin
					o.hops = r.position;
					o.read_value = slot_value(walk_links(r.position));
				end
			end
			MODE_INSERT: begin
				if (r.position > list_len)
					o.status = STATUS_BAD_INDEX;
				else begin
					o.hops = r.position - POS_W'(1);
					prev = walk_links(r.position - 1);
					s = take_slot(r.item_value, follow(prev));
					relink(prev, s);
					list_len++;
				end
			end
			MODE_REMOVE: begin
				if (r.position >= list_len)
					o.status = STATUS_BAD_INDEX;
				else if (r.position == 0) begin
					victim = head_ptr;
					o.read_value = slot_value(victim);
					head_ptr = follow(victim);
					release_slot(victim);
					list_len--;
				end else begin
					o.hops = r.position - POS_W'(1);
					prev = walk_links(r.position - 1);
					victim = follow(prev);
					o.read_value = slot_value(victim);
					relink(prev, follow(victim));
					release_slot(victim);
					list_len--;
				end
			end
			MODE_FIND: begin
				i = 0;
				s = head_ptr;
				while (s != NULL_LINK && i < list_len && !o.found) begin
					if (node_val[s[SLOT_W-1:0]] == r.item_value) begin
						o.found = 1'b1;
						o.found_index = FIDX_W'(i);
					end else begin
						s = follow(s);
						i++;
					end
				end
				o.hops = CNT_W'(i);
			end
			MODE_CLEAR: begin
				empty_list();
			end
			default: begin
			end
			endcase
		end
		o.length = list_len;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h expected %0h",
				checked_count, name, got, want));
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (list_results_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing outstanding", checked_count));
			return;
		end
		want = list_results_due.pop_front();
		compare_field("status", VALUE_W'(got.status), VALUE_W'(want.status));
		compare_field("read_value", got.read_value, want.read_value);
		compare_field("found", VALUE_W'(got.found), VALUE_W'(want.found));
		compare_field("found_index", VALUE_W'(got.found_index), VALUE_W'(want.found_index));
		compare_field("hops", VALUE_W'(got.hops), VALUE_W'(want.hops));
		compare_field("length", VALUE_W'(got.length), VALUE_W'(want.length));
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return {1'b1, {(VALUE_W-1){1'b0}}};
		1: return {1'b0, {(VALUE_W-1){1'b1}}};
		2: return '1;
		3, 4, 5: return VALUE_W'($urandom_range(0, 15));
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_search_value();
		if (recent_values.size() != 0 && $urandom_range(0, 1) == 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		return pick_value();
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_left != 0 || hold_left != 0)
			return 0;
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// queue one request and follow the list length it leaves
	task automatic queue_request(input logic [MODE_W-1:0] m, input int pos,
			input logic [VALUE_W-1:0] v);
		req_t r;
		r.mode = m;
		r.position = POS_W'(pos);
		r.item_value = v;
		request_backlog.push_back(r);
		if (m != MODE_UNUSED)
			useful_queued++;
		case (m)
		MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
			if (gen_len < POOL_DEPTH)
				gen_len++;
		end
		MODE_INSERT: begin
			if (pos <= gen_len && gen_len < POOL_DEPTH)
				gen_len++;
		end
		MODE_REMOVE: begin
			if (pos < gen_len)
				gen_len--;
		end
		MODE_CLEAR: gen_len = 0;
		default: begin
		end
		endcase
		if (m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK || m == MODE_INSERT) begin
			recent_values.push_back(v);
			if (recent_values.size() > 32)
				void'(recent_values.pop_front());
		end
	endtask

	function automatic int valid_index();
		if (gen_len != 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, gen_len - 1);
		return $urandom_range(gen_len, 127);
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				due_rsp = apply_list_request(req);
				list_results_due.push_back(due_rsp);
				accepted_count <= accepted_count + 1;
				if (due_rsp.status == STATUS_FULL)
					full_seen++;
				if (due_rsp.status == STATUS_BAD_INDEX)
					bad_seen++;
				if (due_rsp.found)
					hit_seen++;
			end
			if (hold_left != 0 && req_valid && req_stall)
				blocked_cycles++;
			if (!req_valid || !req_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					req <= request_backlog.pop_front();
					req_valid <= 1'b1;
					send_gap <= pick_idle();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp);
				checked_count++;
			end
			if (hold_left != 0)
				rsp_stall <= 1'b1;
			else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				recv_gap <= pick_idle();
			end
		end
	end

	// long receiver hold-off and stretches without idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
			quiet_left <= 0;
		end else begin
			if (!hold_done && accepted_count >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0)
				hold_left <= hold_left - 1;
			if (quiet_left != 0)
				quiet_left <= quiet_left - 1;
			else if ($urandom_range(0, 299) == 0)
				quiet_left <= $urandom_range(100, 400);
		end
	end

	initial begin
		int kind, n, target, base;
		logic [MODE_W-1:0] m;
		for (int k = 0; k < POOL_DEPTH; k++)
			node_val[k] = '0;
		empty_list();

		// empty list corners
		queue_request(MODE_GET, 0, 32'd0);
		queue_request(MODE_REMOVE, 0, 32'd0);
		queue_request(MODE_FIND, 0, 32'd5);
		queue_request(MODE_UNUSED, 127, '1);
		queue_request(MODE_INSERT, 1, 32'd3);
		// build [-1, min, 7, max, 0, 1]
		queue_request(MODE_PUSH_BACK, 0, 32'h7fff_ffff);
		queue_request(MODE_PUSH_FRONT, 0, 32'h8000_0000);
		queue_request(MODE_PUSH_BACK, 127, 32'd0);
		queue_request(MODE_INSERT, 0, '1);
		queue_request(MODE_INSERT, 4, 32'd1);
		queue_request(MODE_INSERT, 2, 32'd7);
		queue_request(MODE_INSERT, 7, 32'd9);
		queue_request(MODE_INSERT, 127, 32'd9);
		queue_request(MODE_GET, 0, 32'd0);
		queue_request(MODE_GET, 5, 32'd0);
		queue_request(MODE_GET, 6, 32'd0);
		queue_request(MODE_GET, 127, 32'd0);
		queue_request(MODE_FIND, 0, '1);
		queue_request(MODE_FIND, 0, 32'd1);
		queue_request(MODE_FIND, 0, 32'd12345);
		queue_request(MODE_REMOVE, 0, 32'd0);
		queue_request(MODE_REMOVE, 4, 32'd0);
		queue_request(MODE_REMOVE, 1, 32'd0);
		queue_request(MODE_REMOVE, 9, 32'd0);
		queue_request(MODE_CLEAR, 0, 32'd0);
		queue_request(MODE_PUSH_FRONT, 0, 32'd42);
		queue_request(MODE_GET, 0, 32'd0);

		base = useful_queued;
		while (useful_queued - base < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				// fill, often up to a full pool, then push against it
				target = $urandom_range(0, 1) ? POOL_DEPTH : $urandom_range(gen_len, POOL_DEPTH);
				while (gen_len < target) begin
					m = MODE_W'($urandom_range(0, 2));
					if (m == MODE_GET)
						m = MODE_INSERT;
					queue_request(m, (m == MODE_INSERT) ? $urandom_range(0, gen_len)
						: $urandom_range(0, 127), pick_value());
				end
				n = $urandom_range(1, 3);
				repeat (n) begin
					m = MODE_W'($urandom_range(0, 2));
					if (m == MODE_GET)
						m = MODE_INSERT;
					queue_request(m, $urandom_range(0, gen_len + 3), pick_value());
				end
			end else if (kind < 45) begin
				// drain toward a shorter list
				target = $urandom_range(0, gen_len);
				while (gen_len > target) begin
					case ($urandom_range(0, 4))
					0: queue_request(MODE_GET, valid_index(), pick_value());
					1: queue_request(MODE_REMOVE, 0, pick_value());
					2: queue_request(MODE_REMOVE, gen_len - 1, pick_value());
					default: queue_request(MODE_REMOVE, $urandom_range(0, gen_len - 1), pick_value());
					endcase
				end
			end else if (kind < 90) begin
				n = $urandom_range(20, 40);
				repeat (n) begin
					m = MODE_W'($urandom_range(0, 5));
					case (m)
					MODE_GET, MODE_REMOVE: queue_request(m, valid_index(), pick_value());
					MODE_INSERT: begin
						if ($urandom_range(0, 9) != 0)
							queue_request(m, $urandom_range(0, gen_len), pick_value());
						else
							queue_request(m, $urandom_range(gen_len + 1, 127), pick_value());
					end
					MODE_FIND: queue_request(m, $urandom_range(0, 127), pick_search_value());
					default: queue_request(m, $urandom_range(0, 127), pick_value());
					endcase
				end
			end else begin
				// noise: any mode, any field value
				n = $urandom_range(3, 8);
				repeat (n)
					queue_request(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || req_valid || list_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d full, %0d bad index, %0d find hits; %0d results checked",
			accepted_count, full_seen, bad_seen, hit_seen, checked_count);
		$display("receiver hold-off of %0d cycles kept the request side stalled for %0d cycles",
			HOLD_CYCLES, blocked_cycles);
		if (error_count == 0)
			$display("[linked_list_table_engine] OK");
		else
			$display("[linked_list_table_engine] ERROR");
		$finish;
	end

	initial begin
		#6000000;
		$display("timeout with %0d results outstanding", list_results_due.size());
		$display("[linked_list_table_engine] ERROR");
		$finish;
	end

endmodule
